### hdl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// constants, types and the arctangent table for the axis-angle rotation core
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W   = 5;
    localparam int DIR_W        = 16;
    localparam int ANGLE_W      = 16;
    localparam int MAT_W        = 18;
    localparam int MAT_ENTRIES  = 9;
    localparam int ENT_W        = 4;
    localparam int IDX_W        = 3;

    // cordic x and y in Q4.30, z in binary angle units
    localparam int CX_W  = 34;
    localparam int CZ_W  = 33;
    localparam int VER_W = 33;

    localparam logic signed [CX_W-1:0]  CORDIC_GAIN  = CX_W'(652032874);
    localparam logic signed [30:0]      RAD_TO_BANG  = 31'sd683565276;
    localparam logic signed [CZ_W-1:0]  QUARTER_TURN = CZ_W'(64'sd1073741824);
    localparam logic signed [CZ_W-1:0]  HALF_TURN    = CZ_W'(64'sd2147483648);
    localparam logic signed [CX_W-1:0]  ONE_Q30      = CX_W'(64'sd1073741824);

    localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(65536);
    localparam logic signed [MAT_W-1:0] MAT_MAX = MAT_W'(131071);
    localparam logic signed [MAT_W-1:0] MAT_MIN = MAT_W'(-131072);

    typedef enum logic [IDX_W-1:0] {
        REG_AXIS_PX = 3'd0,
        REG_AXIS_PY = 3'd1,
        REG_AXIS_PZ = 3'd2,
        REG_AXIS_DX = 3'd3,
        REG_AXIS_DY = 3'd4,
        REG_AXIS_DZ = 3'd5,
        REG_ANGLE   = 3'd6
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ANGLE  = 4'b0010,
        ST_ROTATE = 4'b0100,
        ST_MATRIX = 4'b1000
    } state_t;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [29:0] atan_bang(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/rotate_point_about_axis_core.sv
// a point accepted into pt_reg passes through the product registers and res_reg to the outputs
// throughput: one point per cycle through the three-stage point pipeline, unless in_stall is high
// after each register write the matrix is rebuilt (angle setup, 16 cordic steps, 9 entries, each
// formed in multiply, multiply and round/store phases); input is stalled for that time
// reset: registers take their reset values and the matrix is the identity at once
// ----------------------------------------------------------------------------
// rotate_point_about_axis_core
// rotates Q16.16 points about a configured axis with a Rodrigues matrix
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_point_about_axis_core
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [rpa_pkg::IDX_W-1:0]             wr_index,
    input  wire logic [rpa_pkg::COORD_WIDTH-1:0]       wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [rpa_pkg::COORD_WIDTH-1:0] point_x,
    input  wire logic signed [rpa_pkg::COORD_WIDTH-1:0] point_y,
    input  wire logic signed [rpa_pkg::COORD_WIDTH-1:0] point_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [rpa_pkg::COORD_WIDTH-1:0]     rotated_x,
    output logic signed [rpa_pkg::COORD_WIDTH-1:0]     rotated_y,
    output logic signed [rpa_pkg::COORD_WIDTH-1:0]     rotated_z
);

    localparam int CW   = rpa_pkg::COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int HW   = DW - 16;
    localparam int PW   = rpa_pkg::MAT_W + HW;
    localparam int SW   = PW + 2;
    localparam int RW   = SW + 3;
    localparam int DDW  = 2 * rpa_pkg::DIR_W;
    localparam int PRW  = DDW + rpa_pkg::VER_W;
    localparam int EXW  = rpa_pkg::DIR_W + rpa_pkg::CX_W;
    localparam int VW   = PRW - 14 + 1;

    localparam logic signed [RW-1:0] RES_MAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] RES_MIN = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // configuration registers
    logic signed [CW-1:0]                 ax_reg [3];
    logic signed [rpa_pkg::DIR_W-1:0]     dir_reg [3];
    logic signed [rpa_pkg::ANGLE_W-1:0]   angle_reg;

    // matrix builder
    rpa_pkg::state_t                      state_reg, state_next;
    logic signed [rpa_pkg::CX_W-1:0]      x_reg, y_reg;
    logic signed [rpa_pkg::CZ_W-1:0]      z_reg;
    logic                                 neg_reg;
    logic [rpa_pkg::CNT_W-1:0]            cnt_reg;
    logic [rpa_pkg::ENT_W-1:0]            ent_reg;
    logic [1:0]                           ph_reg;
    logic signed [DDW-1:0]                dd_reg;
    logic signed [EXW-1:0]                extra_reg;
    logic signed [rpa_pkg::VER_W-1:0]     vers_reg;
    logic signed [PRW-1:0]                prod_reg;
    logic signed [rpa_pkg::MAT_W-1:0]     mat_reg [rpa_pkg::MAT_ENTRIES];

    logic signed [46:0]                   bang_prod;
    logic signed [rpa_pkg::CZ_W-1:0]      z0;
    logic signed [rpa_pkg::CX_W-1:0]      xs, ys, cval, sval;
    logic signed [rpa_pkg::CZ_W-1:0]      atan_val;
    logic signed [rpa_pkg::DIR_W-1:0]     da, db, dk;
    logic                                 diag, ksub;
    logic signed [EXW-1:0]                ks;
    logic signed [rpa_pkg::CX_W:0]        vers_full;
    logic signed [VW-1:0]                 vsum;
    logic signed [VW-29:0]                vrnd;
    logic signed [rpa_pkg::MAT_W-1:0]     mat_new;

    // point pipeline
    logic                                 s0_valid_reg, s1_valid_reg, out_valid_reg;
    logic signed [CW-1:0]                 pt_reg [3];
    logic signed [CW-1:0]                 pass_reg [3];
    logic signed [PW-1:0]                 ph_prod_reg [9];
    logic signed [PW-1:0]                 pl_prod_reg [9];
    logic signed [CW-1:0]                 res_reg [3];
    logic signed [PW-1:0]                 ph_prod_next [9];
    logic signed [PW-1:0]                 pl_prod_next [9];
    logic signed [CW-1:0]                 res_next [3];
    logic                                 advance;
    logic                                 busy;
    logic                                 angle_zero;

    assign busy       = (state_reg != rpa_pkg::ST_IDLE);
    assign angle_zero = (angle_reg == '0);
    assign advance    = !out_valid_reg || !out_stall;
    assign in_stall   = busy || !advance;

    assign out_valid = out_valid_reg;
    assign rotated_x = res_reg[0];
    assign rotated_y = res_reg[1];
    assign rotated_z = res_reg[2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg[0] <= '0;
            ax_reg[1] <= '0;
            ax_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= rpa_pkg::DIR_W'(16384);
            angle_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rpa_pkg::REG_AXIS_PX: ax_reg[0] <= wr_data;
                rpa_pkg::REG_AXIS_PY: ax_reg[1] <= wr_data;
                rpa_pkg::REG_AXIS_PZ: ax_reg[2] <= wr_data;
                rpa_pkg::REG_AXIS_DX: dir_reg[0] <= wr_data[rpa_pkg::DIR_W-1:0];
                rpa_pkg::REG_AXIS_DY: dir_reg[1] <= wr_data[rpa_pkg::DIR_W-1:0];
                rpa_pkg::REG_AXIS_DZ: dir_reg[2] <= wr_data[rpa_pkg::DIR_W-1:0];
                rpa_pkg::REG_ANGLE:   angle_reg <= wr_data[rpa_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // angle to binary angle, folded into +-90 degrees
    always_comb
    begin
        bang_prod = 47'(angle_reg) * 47'(rpa_pkg::RAD_TO_BANG);
        z0 = rpa_pkg::CZ_W'($signed(bang_prod[43:12]));
    end

    always_comb
    begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        atan_val = rpa_pkg::CZ_W'(rpa_pkg::atan_bang(rpa_pkg::ATAN_IDX_W'(cnt_reg)));
        cval     = neg_reg ? -x_reg : x_reg;
        sval     = neg_reg ? -y_reg : y_reg;
    end

    // entry selection, row major: diagonal gets c, off-diagonal +-dk*s
    always_comb
    begin
        da = dir_reg[0];
        db = dir_reg[0];
        dk = dir_reg[0];
        diag = 1'b0;
        ksub = 1'b0;
        case (ent_reg)
            4'd0: begin da = dir_reg[0]; db = dir_reg[0]; diag = 1'b1; end
            4'd1: begin da = dir_reg[0]; db = dir_reg[1]; dk = dir_reg[2]; ksub = 1'b1; end
            4'd2: begin da = dir_reg[0]; db = dir_reg[2]; dk = dir_reg[1]; end
            4'd3: begin da = dir_reg[0]; db = dir_reg[1]; dk = dir_reg[2]; end
            4'd4: begin da = dir_reg[1]; db = dir_reg[1]; diag = 1'b1; end
            4'd5: begin da = dir_reg[1]; db = dir_reg[2]; dk = dir_reg[0]; ksub = 1'b1; end
            4'd6: begin da = dir_reg[0]; db = dir_reg[2]; dk = dir_reg[1]; ksub = 1'b1; end
            4'd7: begin da = dir_reg[1]; db = dir_reg[2]; dk = dir_reg[0]; end
            default: begin da = dir_reg[2]; db = dir_reg[2]; diag = 1'b1; end
        endcase
        ks = EXW'(dk) * EXW'(sval);
        vers_full = (rpa_pkg::CX_W+1)'(rpa_pkg::ONE_Q30) - (rpa_pkg::CX_W+1)'(cval);
    end

    // round to 2^-16 and saturate to the matrix format; a zero angle gives the identity
    always_comb
    begin
        vsum = VW'(prod_reg >>> 14) + VW'(extra_reg);
        vrnd = (VW-28)'((vsum + VW'(64'sd134217728)) >>> 28);
        if (vrnd > (VW-28)'(rpa_pkg::MAT_MAX))
            mat_new = rpa_pkg::MAT_MAX;
        else if (vrnd < (VW-28)'(rpa_pkg::MAT_MIN))
            mat_new = rpa_pkg::MAT_MIN;
        else
            mat_new = rpa_pkg::MAT_W'(vrnd);
        if (angle_zero)
            mat_new = (ent_reg == 4'd0 || ent_reg == 4'd4 || ent_reg == 4'd8)
                      ? rpa_pkg::MAT_ONE : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpa_pkg::ST_IDLE:   state_next = rpa_pkg::ST_IDLE;
            rpa_pkg::ST_ANGLE:  state_next = rpa_pkg::ST_ROTATE;
            rpa_pkg::ST_ROTATE:
                if (cnt_reg == rpa_pkg::CNT_W'(rpa_pkg::CORDIC_STEPS - 1))
                    state_next = rpa_pkg::ST_MATRIX;
            rpa_pkg::ST_MATRIX:
                if (ph_reg == 2'd2 && ent_reg == rpa_pkg::ENT_W'(rpa_pkg::MAT_ENTRIES - 1))
                    state_next = rpa_pkg::ST_IDLE;
            default:            state_next = rpa_pkg::ST_IDLE;
        endcase
        if (wr_en)
            state_next = rpa_pkg::ST_ANGLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpa_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ent_reg   <= '0;
            ph_reg    <= '0;
            neg_reg   <= 1'b0;
            for (int i = 0; i < rpa_pkg::MAT_ENTRIES; i++)
            begin
                mat_reg[i] <= (i % 4 == 0) ? rpa_pkg::MAT_ONE : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                rpa_pkg::ST_ANGLE:
                begin
                    x_reg   <= rpa_pkg::CORDIC_GAIN;
                    y_reg   <= '0;
                    cnt_reg <= '0;
                    ent_reg <= '0;
                    ph_reg  <= '0;
                    if (z0 > rpa_pkg::QUARTER_TURN)
                    begin
                        z_reg   <= z0 - rpa_pkg::HALF_TURN;
                        neg_reg <= 1'b1;
                    end
                    else if (z0 < -rpa_pkg::QUARTER_TURN)
                    begin
                        z_reg   <= z0 + rpa_pkg::HALF_TURN;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg   <= z0;
                        neg_reg <= 1'b0;
                    end
                end
                rpa_pkg::ST_ROTATE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!z_reg[rpa_pkg::CZ_W-1])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_val;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_val;
                    end
                end
                rpa_pkg::ST_MATRIX:
                begin
                    case (ph_reg)
                        2'd0:
                        begin
                            dd_reg    <= DDW'(da) * DDW'(db);
                            vers_reg  <= rpa_pkg::VER_W'(vers_full);
                            if (diag)
                                extra_reg <= EXW'(cval) <<< 14;
                            else
                                extra_reg <= ksub ? -ks : ks;
                            ph_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            prod_reg <= PRW'(dd_reg) * PRW'(vers_reg);
                            ph_reg   <= 2'd2;
                        end
                        default:
                        begin
                            mat_reg[ent_reg] <= mat_new;
                            ent_reg <= ent_reg + 1'b1;
                            ph_reg  <= 2'd0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // stage 1: offset from the axis point, split at 2^-16, then matrix products
    always_comb
    begin
        logic signed [DW-1:0] diff;
        logic signed [HW-1:0] dh [3];
        logic signed [HW-1:0] dl [3];
        for (int k = 0; k < 3; k++)
        begin
            diff  = DW'(pt_reg[k]) - DW'(ax_reg[k]);
            dh[k] = diff[DW-1:16];
            dl[k] = HW'({1'b0, diff[15:0]});
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_prod_next[r*3+k] = PW'(mat_reg[r*3+k]) * PW'(dh[k]);
                pl_prod_next[r*3+k] = PW'(mat_reg[r*3+k]) * PW'(dl[k]);
            end
        end
    end

    // stage 2: row sums, rounding, add the axis point back, saturate; a zero angle passes the point through
    always_comb
    begin
        logic signed [SW-1:0] hs;
        logic signed [SW-1:0] ls;
        logic signed [RW-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            hs  = SW'(ph_prod_reg[r*3]) + SW'(ph_prod_reg[r*3+1]) + SW'(ph_prod_reg[r*3+2]);
            ls  = SW'(pl_prod_reg[r*3]) + SW'(pl_prod_reg[r*3+1]) + SW'(pl_prod_reg[r*3+2]);
            acc = RW'(hs) + RW'((ls + SW'(32768)) >>> 16) + RW'(ax_reg[r]);
            if (angle_zero)
                res_next[r] = pass_reg[r];
            else if (acc > RES_MAX)
                res_next[r] = {1'b0, {(CW-1){1'b1}}};
            else if (acc < RES_MIN)
                res_next[r] = {1'b1, {(CW-1){1'b0}}};
            else
                res_next[r] = CW'(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= in_valid && !busy;
            s1_valid_reg  <= s0_valid_reg;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            for (int k = 0; k < 3; k++)
            begin
                pass_reg[k] <= pt_reg[k];
                res_reg[k]  <= res_next[k];
            end
            for (int i = 0; i < 9; i++)
            begin
                ph_prod_reg[i] <= ph_prod_next[i];
                pl_prod_reg[i] <= pl_prod_next[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_item_while_building: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("item taken while matrix is being rebuilt");

    a_write_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == rpa_pkg::ST_ANGLE))
        else $error("register write did not start a matrix rebuild");

    a_item_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s0_valid_reg)
        else $error("accepted item lost at the input stage");
`endif

endmodule

`default_nettype wire
